[hw/rtl/tkpc_pkg.sv]
package tkpc_pkg;

  // Widths of the configuration registers and the tick counter.
  localparam int unsigned CntW = 16;

  // Reset values of the configuration registers.
  localparam logic [CntW-1:0] DebounceReset = 16'd20;
  localparam logic [CntW-1:0] LongPressReset = 16'd800;
  localparam logic ActiveHighReset = 1'b1;

  // Key phase, as reported on the result channel.
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2,
    PH_LONG     = 2'd3
  } tkpc_phase_t;

  // Event code given with every result.
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_CLICK      = 3'd1,
    EV_LONG_START = 3'd2,
    EV_LONG_STOP  = 3'd3,
    EV_LONG_TICK  = 3'd4
  } tkpc_event_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_POLARITY   = 2'd2
  } tkpc_cfg_idx_t;

  // One tick request.
  typedef struct packed {
    logic pin_level;
    logic ready_req;
    logic light_enabled;
  } tkpc_in_t;

  // One result.
  typedef struct packed {
    logic [2:0] event_res;
    logic [1:0] phase;
  } tkpc_out_t;

endpackage

[hw/rtl/touch_key_press_classifier_top.sv]
// Touch key press classifier. Each tick request on the in_ channel yields exactly one
// result on the out_ channel: an event code (none, click, long start, long stop, long
// repeat tick) and the key phase after that tick. A request is latched into an input
// register. When the output register is free or being drained, the phase machine and
// tick counter are updated and the result is loaded into an output register. One
// request is taken every cycle while results are drained; out_stall holds back both
// registers in turn. Configuration writes are always taken (cfg_ready is high) and
// must be issued only while no request is in flight.
module touch_key_press_classifier_top
  import tkpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  tkpc_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output tkpc_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [CntW-1:0] cfg_data
);

  // Configuration registers.
  logic [CntW-1:0] debounce_ticks_r;
  logic [CntW-1:0] long_press_ticks_r;
  logic            active_high_r;

  // Key state.
  tkpc_phase_t     phase_r, phase_nxt;
  logic [CntW-1:0] tick_count_r, tick_count_nxt;
  logic            dimming_r, dimming_nxt;

  // Pipeline registers.
  logic        s1_vld_r;
  tkpc_in_t    s1_data_r;
  logic        out_vld_r;
  tkpc_out_t   out_data_r;
  tkpc_event_t event_nxt;

  logic            advance;
  logic            pressed;
  logic [CntW-1:0] cnt_inc;

  assign cfg_ready = 1'b1;

  // The input stage moves on when the result register is free or being drained.
  assign advance  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !advance;

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Pin polarity and the incremented counter.
  assign pressed = active_high_r ? s1_data_r.pin_level : !s1_data_r.pin_level;
  assign cnt_inc = tick_count_r + 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r   <= DebounceReset;
      long_press_ticks_r <= LongPressReset;
      active_high_r      <= ActiveHighReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE:   debounce_ticks_r   <= cfg_data;
        CFG_LONG_PRESS: long_press_ticks_r <= cfg_data;
        CFG_POLARITY:   active_high_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next phase, counter and dimming flag.
  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    dimming_nxt    = dimming_r;
    if (s1_data_r.ready_req) begin
      case (phase_r)
        PH_IDLE: begin
          if (pressed) begin
            phase_nxt      = PH_DEBOUNCE;
            tick_count_nxt = '0;
          end
        end
        PH_DEBOUNCE: begin
          tick_count_nxt = cnt_inc;
          if (!pressed) begin
            phase_nxt      = PH_IDLE;
            tick_count_nxt = '0;
          end else if (cnt_inc >= debounce_ticks_r) begin
            phase_nxt      = PH_PRESSED;
            tick_count_nxt = '0;
          end
        end
        PH_PRESSED: begin
          tick_count_nxt = cnt_inc;
          if (!pressed) begin
            phase_nxt      = PH_IDLE;
            tick_count_nxt = '0;
            dimming_nxt    = 1'b0;
          end else if (cnt_inc >= long_press_ticks_r) begin
            phase_nxt      = PH_LONG;
            tick_count_nxt = '0;
            dimming_nxt    = s1_data_r.light_enabled;
          end
        end
        PH_LONG: begin
          if (!pressed) begin
            phase_nxt      = PH_IDLE;
            tick_count_nxt = '0;
            dimming_nxt    = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Event for this tick.
  always_comb begin
    event_nxt = EV_NONE;
    if (s1_data_r.ready_req) begin
      case (phase_r)
        PH_PRESSED: begin
          if (!pressed) begin
            event_nxt = EV_CLICK;
          end else if (cnt_inc >= long_press_ticks_r) begin
            event_nxt = s1_data_r.light_enabled ? EV_LONG_START : EV_CLICK;
          end
        end
        PH_LONG: begin
          if (!pressed) begin
            event_nxt = EV_LONG_STOP;
          end else if (dimming_r) begin
            event_nxt = EV_LONG_TICK;
          end
        end
        default: event_nxt = EV_NONE;
      endcase
    end
  end

  // Control state: valid flags and the key state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      phase_r      <= PH_IDLE;
      tick_count_r <= '0;
      dimming_r    <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r    <= 1'b1;
        phase_r      <= phase_nxt;
        tick_count_r <= tick_count_nxt;
        dimming_r    <= dimming_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r.event_res <= event_nxt;
      out_data_r.phase     <= phase_nxt;
    end
  end

endmodule

[hw/rtl/tkpc_checker.sv]
module tkpc_checker
  import tkpc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input tkpc_out_t out_data
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Long start and repeat ticks are only given in the long press phase.
  a_long_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == EV_LONG_START || out_data.event_res == EV_LONG_TICK)
    |-> out_data.phase == PH_LONG)
    else $error("long event outside long press phase");

  // Long stop always returns to idle.
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res == EV_LONG_STOP |-> out_data.phase == PH_IDLE)
    else $error("long stop without return to idle");

  // A click ends in idle or, with the light off, in the long press phase.
  a_click_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res == EV_CLICK
    |-> out_data.phase == PH_IDLE || out_data.phase == PH_LONG)
    else $error("click in unexpected phase");

endmodule

bind touch_key_press_classifier_top tkpc_checker u_tkpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
